// File: rtl/rdc_pkg.sv
// Shared types, constants and helpers for the radix digit converter.
// Used by rdc_front, rdc_queue, rdc_back and radix_digit_converter_unit.
`default_nettype none

package rdc_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int MAX_DIGITS  = 31;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'd65;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  // Divider: quotient bits resolved per cycle, cycles per digit.
  localparam int STEPS_PER_CYC = 8;
  localparam int DIV_CYC = (VALUE_WIDTH + STEPS_PER_CYC - 1) / STEPS_PER_CYC;
  localparam int DIV_W   = DIV_CYC * STEPS_PER_CYC;
  localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int IDX_W   = $clog2(MAX_DIGITS);

  // Queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_t;

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end else begin
      return r;
    end
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end else begin
      return CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/rdc_front.sv
// Front end: radix register, input handshake, zero filtering.
// Depends on rdc_pkg.
`default_nettype none

module rdc_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rdc_pkg::RADIX_W-1:0]    cfg_radix,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rdc_pkg::VALUE_WIDTH-1:0] in_value,
  input  wire logic                           q_full,
  output logic                                q_push,
  output rdc_pkg::job_t                       q_job
);

  logic [rdc_pkg::RADIX_W-1:0] radix_r;
  logic [rdc_pkg::RADIX_W-1:0] radix_nxt;
  logic                        accept;

  assign cfg_ready = 1'b1;

  always_comb begin
    radix_nxt = radix_r;
    if (cfg_valid) begin
      radix_nxt = cfg_radix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rdc_pkg::RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // zero has no digits: accept and drop
  assign q_push      = accept && (in_value != '0);
  assign q_job.value = in_value;
  assign q_job.radix = rdc_pkg::sat_radix(radix_r);

endmodule

`default_nettype wire

// File: rtl/rdc_queue.sv
// Short job queue decoupling front end and back end.
// Depends on rdc_pkg.
`default_nettype none

module rdc_queue (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire rdc_pkg::job_t push_job,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output rdc_pkg::job_t head_job
);

  rdc_pkg::job_t                 mem_r [rdc_pkg::QUEUE_DEPTH];
  logic [rdc_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [rdc_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [rdc_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign full      = (cnt_r == rdc_pkg::QCNT_W'(rdc_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_job  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rdc_back.sv
// Back end: iterative radix divider, digit buffer, reversed emission
// through an output register. Depends on rdc_pkg.
`default_nettype none

module rdc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_not_empty,
  input  wire rdc_pkg::job_t                 q_job,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rdc_pkg::CHAR_W-1:0]         out_digit_char,
  output logic                               out_last_digit
);

  rdc_pkg::back_state_t state_r, state_nxt;

  logic [rdc_pkg::DIV_W-1:0]   work_r, work_nxt;
  logic [rdc_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic [rdc_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [rdc_pkg::CYC_W-1:0]   cyc_r, cyc_nxt;
  logic [rdc_pkg::IDX_W-1:0]   idx_r, idx_nxt;

  logic [rdc_pkg::DIGIT_W-1:0] dig_buf_r [rdc_pkg::MAX_DIGITS];
  logic                        buf_we;

  logic                        out_valid_r, out_valid_nxt;
  logic [rdc_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_free;

  // one cycle of the shared divider
  logic [rdc_pkg::DIV_W-1:0]   div_work;
  logic [rdc_pkg::RADIX_W-1:0] div_rem;

  always_comb begin
    logic [rdc_pkg::DIV_W-1:0]   w;
    logic [rdc_pkg::RADIX_W-1:0] t;
    w = work_r;
    t = rdc_pkg::RADIX_W'(rem_r);
    for (int i = 0; i < rdc_pkg::STEPS_PER_CYC; i++) begin
      t = {t[rdc_pkg::DIGIT_W-1:0], w[rdc_pkg::DIV_W-1]};
      w = {w[rdc_pkg::DIV_W-2:0], 1'b0};
      if (t >= radix_r) begin
        t    = t - radix_r;
        w[0] = 1'b1;
      end
    end
    div_work = w;
    div_rem  = t;
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    radix_nxt     = radix_r;
    rem_nxt       = rem_r;
    cyc_nxt       = cyc_r;
    idx_nxt       = idx_r;
    buf_we        = 1'b0;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      rdc_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          work_nxt  = rdc_pkg::DIV_W'(q_job.value);
          radix_nxt = q_job.radix;
          rem_nxt   = '0;
          cyc_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = rdc_pkg::BK_DIV;
        end
      end
      rdc_pkg::BK_DIV: begin
        work_nxt = div_work;
        rem_nxt  = div_rem[rdc_pkg::DIGIT_W-1:0];
        cyc_nxt  = cyc_r + 1'b1;
        if (cyc_r == rdc_pkg::CYC_W'(rdc_pkg::DIV_CYC - 1)) begin
          // digit complete; quotient becomes next dividend
          buf_we  = 1'b1;
          rem_nxt = '0;
          cyc_nxt = '0;
          if (div_work == '0 ||
              idx_r == rdc_pkg::IDX_W'(rdc_pkg::MAX_DIGITS - 1)) begin
            state_nxt = rdc_pkg::BK_EMIT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      rdc_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rdc_pkg::digit_char(dig_buf_r[idx_r]);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = rdc_pkg::BK_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = rdc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdc_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      cyc_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cyc_r       <= cyc_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    radix_r    <= radix_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      dig_buf_r[idx_r] <= div_rem[rdc_pkg::DIGIT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule

`default_nettype wire

// File: rtl/radix_digit_converter_unit.sv
// Radix digit converter top level: integer in, ASCII digits out, MSB first.
// Path: front end, job queue, back end divider (8 quotient bits resolved per
// cycle), digit buffer, output register. The single shared divider works on
// one value at a time while the queue accepts further values; digits leave
// one per cycle while out_stall is low.
// Reset: rst_n synchronous active low; radix returns to 10, queue empties.
`default_nettype none

module radix_digit_converter_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration: radix register
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rdc_pkg::RADIX_W-1:0]     cfg_radix,
  // input items
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [rdc_pkg::VALUE_WIDTH-1:0] in_value,
  // result items
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [rdc_pkg::CHAR_W-1:0]           out_digit_char,
  output logic                                 out_last_digit
);

  // front -> queue
  logic          q_push;
  rdc_pkg::job_t q_push_job;
  logic          q_full;
  // queue -> back
  logic          q_pop;
  logic          q_not_empty;
  rdc_pkg::job_t q_head_job;

  // Front end holds the radix register (saturated to 2..16 per item) and
  // drops zero values, which produce no digits.
  rdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_radix (cfg_radix),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_push_job)
  );

  // Two-entry job queue lets input keep flowing while a conversion runs.
  rdc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (q_head_job)
  );

  // Back end: repeated division by the radix (remainder = next digit,
  // least significant first into a buffer), then read back in reverse
  // through the output register, flagging the final digit.
  rdc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_job          (q_head_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

`default_nettype wire

// File: dv/digit_stream_checker.sv
// Digit stream checker for radix_digit_converter_unit: tracks the radix
// register, predicts the ASCII digits of each accepted value and compares them.
// Depends on rdc_pkg for widths and character constants.
module digit_stream_checker
  import rdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [RADIX_W-1:0]     cfg_radix,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [CHAR_W-1:0]      out_digit_char,
  input  logic                   out_last_digit,
  output int                     mismatch_count,
  output int                     digits_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_item_t;

  digit_item_t        expected_digits[$];
  logic [RADIX_W-1:0] radix_q;

  // Queue the digits of one value, most significant first.
  function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] value,
                                         input logic [RADIX_W-1:0] radix_raw);
    logic [VALUE_WIDTH-1:0] rem;
    logic [RADIX_W-1:0]     base;
    logic [DIGIT_W-1:0]     digit;
    digit_item_t            run[$];
    digit_item_t            item;
    base = radix_raw;
    if (radix_raw < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_raw > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    rem = value;
    while (rem != '0) begin
      digit     = DIGIT_W'(rem % base);
      item.ch   = (digit < DIGIT_TEN) ? CHAR_ZERO + CHAR_W'(digit)
                                      : CHAR_A + CHAR_W'(digit - DIGIT_TEN);
      item.last = (run.size() == 0);
      run.push_front(item);
      rem = rem / base;
    end
    // keep only the low-order digits if the run is too long
    while (run.size() > MAX_DIGITS) begin
      void'(run.pop_front());
    end
    expected_digits = {expected_digits, run};
  endfunction

  always @(posedge clk) begin
    digit_item_t want;
    if (!rst_n) begin
      radix_q        = RADIX_RESET;
      mismatch_count = 0;
      expected_digits.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit: expected none, actual char %h last %b",
                   $time, out_digit_char, out_last_digit);
          mismatch_count++;
        end else begin
          want = expected_digits.pop_front();
          if (out_digit_char !== want.ch) begin
            $display("%0t: digit_char mismatch: expected %h actual %h",
                     $time, want.ch, out_digit_char);
            mismatch_count++;
          end
          if (out_last_digit !== want.last) begin
            $display("%0t: last_digit mismatch: expected %b actual %b",
                     $time, want.last, out_last_digit);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_digits(in_value, radix_q);
      end
      if (cfg_valid && cfg_ready) begin
        radix_q = cfg_radix;
      end
    end
    digits_pending = expected_digits.size();
  end

endmodule

// File: dv/radix_digit_converter_unit_tb.sv
// Testbench top for radix_digit_converter_unit: clock, reset, value and
// radix stimulus, receiver stalls and the verdict.
// Depends on rdc_pkg, the unit RTL and digit_stream_checker.
module radix_digit_converter_unit_tb;
  import rdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The slowest item is radix 2 with 31 digits, and the unit holds up to two
  // queued items, so this covers any trailing zero items.
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 18;
  localparam int PRESSURE_ITEMS = 10;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [RADIX_W-1:0]     cfg_radix;
  logic                   in_valid;
  logic                   in_stall;
  logic [VALUE_WIDTH-1:0] in_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [CHAR_W-1:0]      out_digit_char;
  logic                   out_last_digit;

  int                     mismatch_count;
  int                     digits_pending;
  int                     cycle_count;
  logic [RADIX_W-1:0]     cur_radix;

  // no_idle: both sides run without gaps; hold_req: receiver long hold-off, taken once
  bit                     no_idle;
  bit                     hold_req;

  radix_digit_converter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_radix      (cfg_radix),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  digit_stream_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_radix      (cfg_radix),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .mismatch_count (mismatch_count),
    .digits_pending (digits_pending)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run limit, counted in clock cycles.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stalls about 13% of cycles, none while no_idle is set,
  // and one long hold-off on request so the unit backs up into its input.
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        held      = 1'b1;
        out_stall = 1'b0;
      end else begin
        out_stall = !no_idle && ($urandom_range(0, 99) < 13);
      end
    end
  end

  // Offer one value; returns after the accepting edge with valid still high.
  task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
    @(negedge clk);
    while (!no_idle && ($urandom_range(0, 99) < 13)) begin
      in_valid = 1'b0;
      in_value = VALUE_WIDTH'($urandom);  // noise while idle
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = value;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every digit is out and the unit has gone quiet.
  task automatic settle_unit();
    @(negedge clk);
    in_valid = 1'b0;
    while (digits_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Radix writes only with the unit idle.
  task automatic write_radix(input logic [RADIX_W-1:0] radix);
    settle_unit();
    cfg_valid = 1'b1;
    cfg_radix = radix;
    cur_radix = radix;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random value shaped by the radix: zeros, short runs, exact powers of
  // the radix and one below them (digit count boundaries), and full width.
  function automatic logic [VALUE_WIDTH-1:0] pick_value(input logic [RADIX_W-1:0] radix);
    longint unsigned base;
    longint unsigned span;
    int              sel;
    base = radix;
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    sel  = $urandom_range(0, 9);
    span = 1;
    if (sel == 0) begin
      return '0;
    end
    if (sel <= 3) begin
      return VALUE_WIDTH'($urandom_range(1, int'(base * base * base)));
    end
    if (sel <= 5) begin
      repeat ($urandom_range(1, 31)) begin
        if (span * base < 64'h8000_0000) begin
          span = span * base;
        end
      end
      return VALUE_WIDTH'(span - $urandom_range(0, 1));
    end
    return VALUE_WIDTH'($urandom);
  endfunction

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_radix = '0;
    in_valid  = 1'b0;
    in_value  = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    cur_radix = RADIX_RESET;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset radix, decimal extremes and zero
    send_value('0);
    send_value(VALUE_WIDTH'(1));
    send_value(VALUE_WIDTH'(9));
    send_value(VALUE_WIDTH'(10));
    send_value('1);
    // binary: single digit, full 31 ones
    write_radix(RADIX_MIN);
    send_value(VALUE_WIDTH'(1));
    send_value('1);
    send_value('0);
    // hex: every letter, two-digit boundary, full width
    write_radix(RADIX_MAX);
    send_value(VALUE_WIDTH'(15));
    send_value(VALUE_WIDTH'(16));
    send_value('1);
    send_value(31'h0ABC_DEF);
    // out-of-range radix values saturate to 2 or 16
    write_radix('0);
    send_value(VALUE_WIDTH'(6));
    write_radix(5'd1);
    send_value(VALUE_WIDTH'(5));
    write_radix(5'd17);
    send_value(VALUE_WIDTH'(255));
    write_radix('1);
    send_value(31'h7ED_CBA9);
    // odd radices
    write_radix(5'd3);
    send_value('1);
    write_radix(5'd13);
    send_value(VALUE_WIDTH'(12));
    send_value(VALUE_WIDTH'(168));

    // Random phases, each with its own radix; one without any idling
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        write_radix(RADIX_MAX);
      end else if (phase == 1) begin
        write_radix(RADIX_MIN);
      end else begin
        write_radix(RADIX_W'($urandom_range(0, 31)));
      end
      no_idle = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_value(pick_value(cur_radix));
      end
      no_idle = 1'b0;
    end

    // Back-pressure: long radix-2 runs while the receiver holds off
    write_radix(RADIX_MIN);
    hold_req = 1'b1;
    for (int n = 0; n < PRESSURE_ITEMS; n++) begin
      send_value({1'b1, (VALUE_WIDTH-1)'($urandom)});
    end

    settle_unit();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rdc_pkg.sv
rtl/rdc_front.sv
rtl/rdc_queue.sv
rtl/rdc_back.sv
rtl/radix_digit_converter_unit.sv
dv/digit_stream_checker.sv
dv/radix_digit_converter_unit_tb.sv
